// ===== rtl/occ_pkg.sv =====
package occ_pkg;

    localparam int GRID_W  = 512;
    localparam int GRID_H  = 512;
    localparam int CELLS   = GRID_W * GRID_H;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int CNT_W   = CELL_AW + 1;
    localparam int COORD_W = 9;
    localparam int CMP_W   = 13;
    localparam int SCORE_W = 7;
    localparam int ERR_W   = 12;

    localparam logic [1:0] CMD_RAY   = 2'd0;
    localparam logic [1:0] CMD_DECAY = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] CLS_UNKNOWN  = 2'd0;
    localparam logic [1:0] CLS_FREE     = 2'd1;
    localparam logic [1:0] CLS_OCCUPIED = 2'd2;

    localparam logic [2:0] REG_HIT_STEP   = 3'd0;
    localparam logic [2:0] REG_MISS_STEP  = 3'd1;
    localparam logic [2:0] REG_FLOOR      = 3'd2;
    localparam logic [2:0] REG_CEILING    = 3'd3;
    localparam logic [2:0] REG_OCC_LEVEL  = 3'd4;
    localparam logic [2:0] REG_FREE_LEVEL = 3'd5;
    localparam logic [2:0] REG_DECAY_STEP = 3'd6;
    localparam logic [2:0] REG_CLR_NO_HIT = 3'd7;

    typedef struct packed {
        logic load;
        logic cnt_inc;
        logic clr_wr;
        logic dec_rd;
        logic walk_rd;
        logic walk_wr;
        logic set_blocked;
        logic end_rd;
        logic end_wr;
        logic read_rd;
        logic read_eval;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       ends_ok;
        logic       walk_en;
        logic       walk_done;
        logic       pos_in_grid;
        logic       wall;
        logic       end_apply;
        logic       read_in_grid;
        logic       cnt_last;
        logic       out_busy;
    } t_dp_sts;

endpackage

// ===== rtl/occ_ctrl.sv =====
module occ_ctrl import occ_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output logic    o_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_START = 12'b000000000100,
        S_WRD   = 12'b000000001000,
        S_WEV   = 12'b000000010000,
        S_ERD   = 12'b000000100000,
        S_EEV   = 12'b000001000000,
        S_DEC   = 12'b000010000000,
        S_DFL   = 12'b000100000000,
        S_RRD   = 12'b001000000000,
        S_REV   = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                case (i_sts.cmd)
                    CMD_RAY: begin
                        if (!i_sts.ends_ok) n_state = S_DONE;
                        else if (i_sts.walk_en) n_state = S_WRD;
                        else n_state = S_ERD;
                    end
                    CMD_DECAY: n_state = S_DEC;
                    CMD_READ:  n_state = S_RRD;
                    default:   n_state = S_DONE;
                endcase
            end
            S_WRD: begin
                if (i_sts.walk_done || !i_sts.pos_in_grid) begin
                    n_state = S_ERD;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                    n_state       = S_WEV;
                end
            end
            S_WEV: begin
                if (i_sts.wall) begin
                    o_cmd.set_blocked = 1'b1;
                    n_state           = S_ERD;
                end else begin
                    o_cmd.walk_wr = 1'b1;
                    n_state       = S_WRD;
                end
            end
            S_ERD: begin
                if (i_sts.end_apply) begin
                    o_cmd.end_rd = 1'b1;
                    n_state      = S_EEV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EEV: begin
                o_cmd.end_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_DEC: begin
                o_cmd.dec_rd  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                if (i_sts.cnt_last) n_state = S_DFL;
            end
            S_DFL: n_state = S_DONE;
            S_RRD: begin
                if (i_sts.read_in_grid) begin
                    o_cmd.read_rd = 1'b1;
                    n_state       = S_REV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_REV: begin
                o_cmd.read_eval = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

endmodule

// ===== rtl/occ_dp.sv =====
module occ_dp import occ_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_dp_cmd      i_cmd,
    output t_dp_sts      o_sts,
    input  logic [63:0]  i_tdata,
    input  logic [1:0]   i_tuser,
    input  logic         i_out_ready,
    output logic         o_out_valid,
    output logic [1:0]   o_cell_class,
    output logic         o_ray_blocked,
    input  logic         i_cfg_valid,
    input  logic [2:0]   i_cfg_index,
    input  logic [6:0]   i_cfg_data
);

    logic [SCORE_W:0] r_mem [CELLS];
    logic [SCORE_W:0] r_rdata;

    logic [3:0]                r_hit_step, r_miss_step, r_decay_step;
    logic signed [SCORE_W-1:0] r_floor, r_ceil, r_occ, r_free;
    logic                      r_cwh;

    logic [1:0]         r_cmd;
    logic [COORD_W-1:0] r_ex, r_ey, r_x, r_y, r_x1, r_y1, r_maj, r_min;
    logic               r_hit, r_fin, r_eig, r_sx, r_sy, r_xmaj, r_ends_ok;
    logic signed [ERR_W-1:0] r_err;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_sw_pend;
    logic [CELL_AW-1:0] r_sw_addr;
    logic [1:0]         r_class;
    logic               r_blocked;

    logic [COORD_W-1:0] in_ox, in_oy, in_cx, in_cy, dx, dy;
    logic               xmaj;
    logic               end_ok;
    logic signed [SCORE_W-1:0] cur_score, wall;
    logic signed [ERR_W-1:0]   e1, e2;
    logic               rd_en, we;
    logic [CELL_AW-1:0] rd_addr, wr_addr, end_addr;
    logic [SCORE_W:0]   wd;
    logic signed [SCORE_W:0] dec_t;

    function automatic logic in_grid(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        in_grid = (CMP_W'(x) < CMP_W'(GRID_W)) && (CMP_W'(y) < CMP_W'(GRID_H));
    endfunction

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        cell_addr = CELL_AW'(CELL_AW'(y) * CELL_AW'(GRID_W) + CELL_AW'(x));
    endfunction

    function automatic logic signed [SCORE_W-1:0] clamp(input logic signed [SCORE_W+1:0] v,
        input logic signed [SCORE_W-1:0] fl, input logic signed [SCORE_W-1:0] ce);
        logic signed [SCORE_W+1:0] t;
        t = v;
        if (t > (SCORE_W+2)'(ce)) t = (SCORE_W+2)'(ce);
        if (t < (SCORE_W+2)'(fl)) t = (SCORE_W+2)'(fl);
        clamp = t[SCORE_W-1:0];
    endfunction

    assign in_ox = i_tdata[8:0];
    assign in_oy = i_tdata[17:9];
    assign in_cx = i_tdata[26:18];
    assign in_cy = i_tdata[35:27];
    assign dx    = (in_ox > in_cx) ? in_ox - in_cx : in_cx - in_ox;
    assign dy    = (in_oy > in_cy) ? in_oy - in_cy : in_cy - in_oy;
    assign xmaj  = dx > dy;

    assign cur_score = r_rdata[SCORE_W-1:0];
    assign wall      = r_xmaj ? r_ceil : r_occ;
    assign end_ok    = r_eig && in_grid(r_ex, r_ey);
    assign end_addr  = cell_addr(r_ex, r_ey);
    assign e1 = r_err - ERR_W'({r_min, 1'b0});
    assign e2 = e1 + ERR_W'({r_maj, 1'b0});

    always_comb begin
        o_sts.cmd          = r_cmd;
        o_sts.ends_ok      = r_ends_ok;
        o_sts.walk_en      = r_hit || r_cwh;
        o_sts.walk_done    = r_xmaj ? (r_x == r_x1) : (r_y == r_y1);
        o_sts.pos_in_grid  = in_grid(r_x, r_y);
        o_sts.wall         = cur_score >= wall;
        o_sts.end_apply    = end_ok && (r_hit || (r_fin && r_cwh));
        o_sts.read_in_grid = in_grid(r_ex, r_ey);
        o_sts.cnt_last     = (r_cnt == CNT_W'(CELLS - 1));
        o_sts.out_busy     = o_out_valid;
    end

    always_comb begin
        rd_en   = i_cmd.dec_rd || i_cmd.walk_rd || i_cmd.end_rd || i_cmd.read_rd;
        rd_addr = i_cmd.dec_rd ? r_cnt[CELL_AW-1:0] :
                  i_cmd.walk_rd ? cell_addr(r_x, r_y) : end_addr;
        dec_t   = (SCORE_W+1)'(cur_score) - (SCORE_W+1)'({1'b0, r_decay_step});
        we      = 1'b1;
        wr_addr = end_addr;
        wd      = '0;
        if (r_sw_pend) begin
            wr_addr = r_sw_addr;
            wd      = r_rdata;
            if (cur_score > 0) wd[SCORE_W-1:0] = dec_t[SCORE_W] ? '0 : dec_t[SCORE_W-1:0];
        end else if (i_cmd.clr_wr) begin
            wr_addr = r_cnt[CELL_AW-1:0];
        end else if (i_cmd.walk_wr) begin
            wr_addr = cell_addr(r_x, r_y);
            wd = {1'b1, clamp((SCORE_W+2)'(cur_score) - (SCORE_W+2)'({1'b0, r_miss_step}),
                              r_floor, r_ceil)};
        end else if (i_cmd.end_wr) begin
            wd = {1'b1, clamp(r_hit ?
                    (SCORE_W+2)'(cur_score) + (SCORE_W+2)'({1'b0, r_hit_step}) :
                    (SCORE_W+2)'(cur_score) - (SCORE_W+2)'({1'b0, r_miss_step}),
                    r_floor, r_ceil)};
        end else begin
            we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wr_addr] <= wd;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_step   <= 4'd3;
            r_miss_step  <= 4'd1;
            r_floor      <= -7'sd20;
            r_ceil       <= 7'sd20;
            r_occ        <= 7'sd3;
            r_free       <= -7'sd3;
            r_decay_step <= 4'd1;
            r_cwh        <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HIT_STEP:   r_hit_step   <= i_cfg_data[3:0];
                REG_MISS_STEP:  r_miss_step  <= i_cfg_data[3:0];
                REG_FLOOR:      r_floor      <= i_cfg_data;
                REG_CEILING:    r_ceil       <= i_cfg_data;
                REG_OCC_LEVEL:  r_occ        <= i_cfg_data;
                REG_FREE_LEVEL: r_free       <= i_cfg_data;
                REG_DECAY_STEP: r_decay_step <= i_cfg_data[3:0];
                REG_CLR_NO_HIT: r_cwh        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_sw_pend   <= 1'b0;
            o_out_valid <= 1'b0;
            r_cmd       <= CMD_RAY;
            r_ends_ok   <= 1'b0;
        end else begin
            r_sw_pend <= i_cmd.dec_rd;
            if (i_cmd.load) r_cnt <= '0;
            else if (i_cmd.cnt_inc) r_cnt <= r_cnt + 1'b1;
            if (i_cmd.out_load) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
            if (i_cmd.load) begin
                r_cmd     <= i_tuser;
                r_ends_ok <= in_grid(in_ox, in_oy) && in_grid(in_cx, in_cy);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw_addr <= r_cnt[CELL_AW-1:0];
        if (i_cmd.load) begin
            r_ex      <= i_tdata[44:36];
            r_ey      <= i_tdata[53:45];
            r_hit     <= i_tdata[54];
            r_fin     <= i_tdata[55];
            r_eig     <= i_tdata[56];
            r_x       <= in_ox;
            r_y       <= in_oy;
            r_x1      <= in_cx;
            r_y1      <= in_cy;
            r_sx      <= in_ox < in_cx;
            r_sy      <= in_oy < in_cy;
            r_xmaj    <= xmaj;
            r_maj     <= xmaj ? dx : dy;
            r_min     <= xmaj ? dy : dx;
            r_err     <= ERR_W'(xmaj ? dx : dy);
            r_class   <= CLS_UNKNOWN;
            r_blocked <= 1'b0;
        end
        if (i_cmd.walk_wr) begin
            r_err <= e1[ERR_W-1] ? e2 : e1;
            if (r_xmaj) begin
                r_x <= r_sx ? r_x + 1'b1 : r_x - 1'b1;
                if (e1[ERR_W-1]) r_y <= r_sy ? r_y + 1'b1 : r_y - 1'b1;
            end else begin
                r_y <= r_sy ? r_y + 1'b1 : r_y - 1'b1;
                if (e1[ERR_W-1]) r_x <= r_sx ? r_x + 1'b1 : r_x - 1'b1;
            end
        end
        if (i_cmd.set_blocked) r_blocked <= 1'b1;
        if (i_cmd.read_eval) begin
            if (!r_rdata[SCORE_W]) r_class <= CLS_UNKNOWN;
            else if (cur_score >= r_occ) r_class <= CLS_OCCUPIED;
            else if (cur_score <= r_free) r_class <= CLS_FREE;
            else r_class <= CLS_UNKNOWN;
        end
        if (i_cmd.out_load) begin
            o_cell_class  <= r_class;
            o_ray_blocked <= r_blocked;
        end
    end

`ifndef SYNTHESIS
    a_no_pending_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_sw_pend) else $error("decay write pending at new request");
    a_walk_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_wr |-> $past(i_cmd.walk_rd)) else $error("walk write without read");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CELLS)) else $error("sweep counter out of range");
`endif

endmodule

// ===== rtl/occupancy_grid_ray_update.sv =====
// Occupancy grid ray update. Requests arrive on the slave stream (tuser = command);
// one result per request leaves on the master stream. After reset the block runs
// a clearing pass over the GRID_W*GRID_H cells of the grid store (262144 at
// 512x512), one cell per cycle, and takes no request until it ends; configuration writes
// are taken at any time. The cell store has one read and one write port with
// registered read data, which sets the timing. A new request is taken only after the
// previous one has handed its result to the output register; a ray reads and then
// writes each cell that it clears, one cell after another.
module occupancy_grid_ray_update import occ_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // start_x, start_y, clear_x, clear_y, end_x, end_y, has_hit, finite_range, end_in_grid
    input  logic [63:0] i_s_tdata,
    // cmd
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // cell_class, ray_blocked
    output logic [7:0]  o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_sts    dp_sts;
    logic [1:0] cell_class;
    logic       ray_blocked;

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {5'd0, ray_blocked, cell_class};

    occ_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (dp_sts),
        .o_ready     (o_s_tready),
        .o_cmd       (dp_cmd)
    );

    occ_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_tdata       (i_s_tdata),
        .i_tuser       (i_s_tuser),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_cell_class  (cell_class),
        .o_ray_blocked (ray_blocked),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

endmodule

// ===== tb/tb_occupancy_grid_ray_update.sv =====
`timescale 1ns / 100ps

module tb_occupancy_grid_ray_update;
    import occ_pkg::*;

    typedef struct {
        logic [1:0] cmd;
        logic [8:0] ox, oy, cx, cy, ex, ey;
        logic       hit, fin, eig;
    } t_req;

    typedef struct {
        logic [1:0] cls;
        logic       blocked;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;

    occupancy_grid_ray_update dut (.*);

    always #2 i_clk = ~i_clk;

    // grid mirror and register copy
    logic signed [6:0] grid_score [0:CELLS-1];
    bit                grid_seen  [0:CELLS-1];
    int hit_step, miss_step, floor_lvl, ceil_lvl, occ_lvl, free_lvl, decay_step, clr_no_hit;

    t_res pending_results[$];
    int   errors = 0;
    int   burst_left = 0;
    int   decays_left = 1;
    int   rx_mode = 0;
    int   rx_left = 0;

    function automatic int clamp_score(int v);
        if (v > ceil_lvl) v = ceil_lvl;
        if (v < floor_lvl) v = floor_lvl;
        return v;
    endfunction

    function automatic int cell_idx(int x, int y);
        return y * GRID_W + x;
    endfunction

    function automatic bit clear_walk(int x0, int y0, int x1, int y1);
        int dx, dy, sx, sy, x, y, err2, wall, majd, mind, i;
        bit xmaj;
        dx = x1 > x0 ? x1 - x0 : x0 - x1;
        dy = y1 > y0 ? y1 - y0 : y0 - y1;
        sx = x0 < x1 ? 1 : -1;
        sy = y0 < y1 ? 1 : -1;
        x = x0;
        y = y0;
        xmaj = dx > dy;
        wall = xmaj ? ceil_lvl : occ_lvl;
        majd = xmaj ? dx : dy;
        mind = xmaj ? dy : dx;
        err2 = majd;
        while (xmaj ? (x != x1) : (y != y1)) begin
            i = cell_idx(x, y);
            if (int'(grid_score[i]) >= wall) return 1'b1;
            grid_seen[i] = 1'b1;
            grid_score[i] = 7'(clamp_score(int'(grid_score[i]) - miss_step));
            err2 -= 2 * mind;
            if (err2 < 0) begin
                if (xmaj) y += sy; else x += sx;
                err2 += 2 * majd;
            end
            if (xmaj) x += sx; else y += sy;
        end
        return 1'b0;
    endfunction

    function automatic t_res predict_result(t_req r);
        t_res o;
        int i, s;
        o.cls = CLS_UNKNOWN;
        o.blocked = 1'b0;
        case (r.cmd)
            CMD_RAY: begin
                if (r.hit || clr_no_hit)
                    o.blocked = clear_walk(int'(r.ox), int'(r.oy), int'(r.cx), int'(r.cy));
                i = cell_idx(int'(r.ex), int'(r.ey));
                if (r.eig && (r.hit || (r.fin && clr_no_hit))) begin
                    grid_seen[i] = 1'b1;
                    grid_score[i] = 7'(clamp_score(int'(grid_score[i])
                                                   + (r.hit ? hit_step : -miss_step)));
                end
            end
            CMD_DECAY: begin
                for (i = 0; i < CELLS; i++) begin
                    s = int'(grid_score[i]);
                    if (s > 0) begin
                        s -= decay_step;
                        grid_score[i] = 7'(s < 0 ? 0 : s);
                    end
                end
            end
            CMD_READ: begin
                i = cell_idx(int'(r.ex), int'(r.ey));
                s = int'(grid_score[i]);
                if (!grid_seen[i]) o.cls = CLS_UNKNOWN;
                else if (s >= occ_lvl) o.cls = CLS_OCCUPIED;
                else if (s <= free_lvl) o.cls = CLS_FREE;
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic send_req(t_req r);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= r.cmd;
        i_s_tdata  <= {7'd0, r.eig, r.fin, r.hit, r.ey, r.ex, r.cy, r.cx, r.oy, r.ox};
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(predict_result(r));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[6:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_HIT_STEP:   hit_step   = val & 15;
            REG_MISS_STEP:  miss_step  = val & 15;
            REG_FLOOR:      floor_lvl  = int'($signed(val[6:0]));
            REG_CEILING:    ceil_lvl   = int'($signed(val[6:0]));
            REG_OCC_LEVEL:  occ_lvl    = int'($signed(val[6:0]));
            REG_FREE_LEVEL: free_lvl   = int'($signed(val[6:0]));
            REG_DECAY_STEP: decay_step = val & 15;
            default:        clr_no_hit = val & 1;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(int hs, int ms, int fl, int cl, int oc, int fr, int ds, int cw);
        drain();
        write_reg(REG_HIT_STEP, hs);
        write_reg(REG_MISS_STEP, ms);
        write_reg(REG_FLOOR, fl);
        write_reg(REG_CEILING, cl);
        write_reg(REG_OCC_LEVEL, oc);
        write_reg(REG_FREE_LEVEL, fr);
        write_reg(REG_DECAY_STEP, ds);
        write_reg(REG_CLR_NO_HIT, cw);
    endtask

    function automatic t_req make_req(logic [1:0] c, int ox, int oy, int cx, int cy,
                                      int ex, int ey, bit h, bit f, bit e);
        t_req r;
        r.cmd = c;
        r.ox = 9'(ox); r.oy = 9'(oy); r.cx = 9'(cx); r.cy = 9'(cy);
        r.ex = 9'(ex); r.ey = 9'(ey);
        r.hit = h; r.fin = f; r.eig = e;
        return r;
    endfunction

    // mostly short rays in a small window so cells get revisited
    function automatic logic [8:0] coord(bit wide, int base);
        return wide ? 9'($urandom_range(0, 511)) : 9'(base + $urandom_range(0, 23));
    endfunction

    task automatic send_random();
        t_req r;
        int k, base;
        bit wide;
        k = $urandom_range(0, 99);
        wide = $urandom_range(0, 9) < 2;
        base = 200;
        r = make_req(CMD_RAY, coord(wide, base), coord(wide, base), coord(wide, base),
                     coord(wide, base), coord(wide, base), coord(wide, base),
                     $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                     $urandom_range(0, 4) != 0);
        if (k < 25) r.cmd = CMD_READ;
        else if (k < 27) r.cmd = 2'd3;
        else if (k == 27 && decays_left > 0) begin
            r.cmd = CMD_DECAY;
            decays_left--;
        end
        if ($urandom_range(0, 7) == 0) begin
            r.cx = r.ox;
            r.cy = r.oy;
        end
        send_req(r);
    endtask

    task automatic test_directed();
        // unobserved read, extremes of coordinates
        send_req(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(make_req(CMD_RAY, 0, 0, 511, 511, 511, 511, 1, 1, 1));
        send_req(make_req(CMD_READ, 0, 0, 0, 0, 511, 511, 0, 0, 0));
        send_req(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // x-major and y-major rays, both directions
        send_req(make_req(CMD_RAY, 40, 10, 10, 20, 5, 20, 1, 1, 1));
        send_req(make_req(CMD_RAY, 10, 40, 20, 10, 20, 5, 1, 1, 1));
        // hit without finite range, origin equal to clear end
        send_req(make_req(CMD_RAY, 30, 30, 30, 30, 30, 31, 1, 0, 1));
        // no hit, no clearing allowed
        send_req(make_req(CMD_RAY, 50, 50, 60, 55, 60, 55, 0, 1, 1));
        // end outside flag clear
        send_req(make_req(CMD_RAY, 50, 50, 60, 55, 61, 55, 1, 1, 0));
        // build a wall at (20,20), pass beside it x-major, then walk through it y-major
        repeat (8) send_req(make_req(CMD_RAY, 20, 20, 20, 20, 20, 20, 1, 1, 1));
        send_req(make_req(CMD_RAY, 10, 20, 30, 22, 30, 22, 1, 1, 1));
        send_req(make_req(CMD_RAY, 20, 10, 21, 30, 21, 30, 1, 1, 1));
        send_req(make_req(CMD_READ, 0, 0, 0, 0, 20, 20, 0, 0, 0));
        send_req(make_req(CMD_READ, 0, 0, 0, 0, 15, 20, 0, 0, 0));
        send_req(make_req(2'd3, 511, 511, 511, 511, 511, 511, 1, 1, 1));
        send_req(make_req(CMD_DECAY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(make_req(CMD_READ, 0, 0, 0, 0, 20, 20, 0, 0, 0));
    endtask

    task automatic test_extreme_config();
        set_regs(15, 15, -64, 63, 63, -64, 15, 1);
        repeat (140) send_random();
        // zero steps, floor above ceiling, free level above occupied level
        set_regs(0, 0, 10, -10, -5, 5, 0, 1);
        repeat (140) send_random();
    endtask

    task automatic test_random_config();
        repeat (3) begin
            set_regs($urandom_range(1, 15), $urandom_range(1, 15), -$urandom_range(1, 64),
                     $urandom_range(0, 63), $urandom_range(0, 20) - 4,
                     -$urandom_range(0, 20), $urandom_range(0, 15), $urandom_range(0, 1));
            repeat (140) send_random();
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(10, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        i_m_tready <= (rx_mode == 0) ? 1'b1 :
                      (rx_mode == 1) ? 1'($urandom_range(0, 1)) :
                      ($urandom_range(0, 7) == 0);
    end

    always @(posedge i_clk) begin
        t_res want;
        if (o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[1:0] !== want.cls) begin
                    $display("%0t: cell_class expected %0d actual %0d",
                             $time, want.cls, o_m_tdata[1:0]);
                    errors++;
                end
                if (o_m_tdata[2] !== want.blocked) begin
                    $display("%0t: ray_blocked expected %0d actual %0d",
                             $time, want.blocked, o_m_tdata[2]);
                    errors++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            grid_score[i] = '0;
            grid_seen[i] = 1'b0;
        end
        hit_step = 3; miss_step = 1; floor_lvl = -20; ceil_lvl = 20;
        occ_lvl = 3; free_lvl = -3; decay_step = 1; clr_no_hit = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_extreme_config();
        test_random_config();
        drain();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/occ_pkg.sv
rtl/occ_ctrl.sv
rtl/occ_dp.sv
rtl/occupancy_grid_ray_update.sv
tb/tb_occupancy_grid_ray_update.sv
